/* src/nca_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nca_pkg: shared definitions for the nearest-centroid assignment block
// Word layouts, register indexes, request codes and the sequencer state type.
// ----------------------------------------------------------------------------
package nca_pkg;

   // default geometry
   localparam int MAX_CLUSTERS_DEF = 16;
   localparam int DIMS_DEF         = 8;
   localparam int COORD_BITS_DEF   = 16;

   // fixed field widths of the request and response words
   localparam int SLOT_W      = 4;   // centroid_index
   localparam int NUM_COORDS  = 8;   // coordinate fields carried in a request word
   localparam int CIDX_W      = 4;   // cluster_index
   localparam int DIST_OUT_W  = 19;  // nearest_dist
   localparam int COUNT_W     = 16;  // cluster_size
   localparam int RSP_W       = 40;  // 4 + 19 + 16, padded to whole bytes

   // configuration port
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int NUMC_W      = 5;
   localparam int DIMS_W      = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_NUM_CLUSTERS = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACTIVE_DIMS  = 1'd1;

   localparam logic [NUMC_W-1:0] NUM_CLUSTERS_RST = 5'd1;
   localparam logic [DIMS_W-1:0] ACTIVE_DIMS_RST  = 4'd8;

   // request kinds carried in tuser
   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // request word width: slot then eight coordinates, padded to bytes
   function automatic int req_width(int coord_bits);
      return ((SLOT_W + NUM_COORDS * coord_bits + 7) / 8) * 8;
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_CNT_RD,
      ST_CNT_WR
   } state_type;

endpackage
`default_nettype wire

/* src/nca_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nca_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* src/nearest_centroid_assign_manhattan.sv */
`default_nettype none
// A load word is written into the centroid RAM when accepted and the block stays ready.
// A classify word is accepted while idle; the distance unit then walks the centroid RAM
// one centroid per cycle over n centroids, n being num_clusters held to 1..MAX_CLUSTERS,
// and the winner's count is read, bumped and registered into the response word. No request
// is taken meanwhile; a response still waiting holds the next classify at its count update.
// Reset (synchronous): registers to num_clusters 1 / active_dims 8, all member counts zero.
// ----------------------------------------------------------------------------
// nearest_centroid_assign_manhattan: Lloyd assignment step, L1 distance
// Loads centroids into a RAM, and for each point walks the active centroids
// through a shared distance unit, keeps the nearest and bumps its count.
// ----------------------------------------------------------------------------
module nearest_centroid_assign_manhattan #(
   parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
   parameter int DIMS         = nca_pkg::DIMS_DEF,
   parameter int COORD_BITS   = nca_pkg::COORD_BITS_DEF
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   // request stream
   input  wire logic                                      req_tvalid,
   output logic                                           req_tready,
   // tdata: centroid_index, coord_0 .. coord_7, zero pad
   input  wire logic [nca_pkg::req_width(COORD_BITS)-1:0] req_tdata,
   // tuser: req_type
   input  wire logic                                      req_tuser,
   input  wire logic                                      req_tlast,
   // response stream
   output logic                                           rsp_tvalid,
   input  wire logic                                      rsp_tready,
   // tdata: cluster_index, nearest_dist, cluster_size, zero pad
   output logic      [nca_pkg::RSP_W-1:0]                 rsp_tdata,
   output logic                                           rsp_tlast,
   // register write channel
   input  wire logic                                      csr_valid,
   output logic                                           csr_ready,
   input  wire logic [nca_pkg::CSR_ADDR_W-1:0]            csr_index,
   input  wire logic [nca_pkg::CSR_DATA_W-1:0]            csr_wdata
);

   import nca_pkg::*;

   localparam int IDXW  = $clog2(MAX_CLUSTERS);
   localparam int ROWW  = DIMS * COORD_BITS;
   localparam int DISTW = COORD_BITS + $clog2(DIMS + 1);

   // --------------------------------------------------------------------
   // declarations
   // --------------------------------------------------------------------
   state_type state_ff, state_in;

   logic [NUMC_W-1:0]     num_clusters_ff, num_clusters_in;
   logic [DIMS_W-1:0]     active_dims_ff, active_dims_in;

   logic                  req_acc, load_acc, cls_acc;
   logic                  issue, finish, out_free;

   logic [SLOT_W-1:0]     slot;
   logic [IDXW-1:0]       slot_idx;
   logic                  slot_ok;
   logic [ROWW-1:0]       row_data;

   logic [ROWW-1:0]       point_ff, point_in;
   logic                  last_ff, last_in;
   logic [DIMS-1:0]       lane_en_ff, lane_en_in;
   logic [IDXW-1:0]       nc_last_ff, nc_last_in;
   logic [DIMS_W-1:0]     nd_eff;
   logic [IDXW-1:0]       k_ff, k_in;

   logic [ROWW-1:0]       cen_rd;

   logic                  p1_vld_ff, p1_vld_in;
   logic [IDXW-1:0]       p1_idx_ff;
   logic                  p1_last_ff;
   logic                  p2_vld_ff, p2_vld_in;
   logic [IDXW-1:0]       p2_idx_ff;
   logic                  p2_last_ff;
   logic [COORD_BITS-1:0] abs_ff [DIMS];
   logic [COORD_BITS-1:0] abs_in [DIMS];
   logic                  p3_vld_ff, p3_vld_in;
   logic [IDXW-1:0]       p3_idx_ff;
   logic                  p3_last_ff;
   logic [DISTW-1:0]      sum_ff, sum_in;

   logic [DISTW-1:0]      best_dist_ff, best_dist_in;
   logic [IDXW-1:0]       best_idx_ff, best_idx_in;

   logic [MAX_CLUSTERS-1:0] cnt_vld_ff, cnt_vld_in;
   logic [COUNT_W-1:0]    cnt_rd, cnt_cur, cnt_new;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CIDX_W-1:0]     out_idx_ff;
   logic [DIST_OUT_W-1:0] out_dist_ff;
   logic [COUNT_W-1:0]    out_cnt_ff;
   logic                  out_last_ff;
   logic [IDXW+CIDX_W-1:0]       idx_wide;
   logic [DISTW+DIST_OUT_W-1:0]  dist_wide;
   logic [IDXW+SLOT_W-1:0]       slot_wide;

   // --------------------------------------------------------------------
   // request decode
   // --------------------------------------------------------------------
   assign req_acc  = req_tvalid && req_tready;
   assign load_acc = req_acc && (req_tuser == REQ_LOAD);
   assign cls_acc  = req_acc && (req_tuser == REQ_CLASSIFY);

   assign slot      = req_tdata[SLOT_W-1:0];
   assign slot_wide = {{IDXW{1'b0}}, slot};
   assign slot_idx  = slot_wide[IDXW-1:0];
   assign slot_ok   = (32'(slot) < 32'(MAX_CLUSTERS));

   // first DIMS coordinates, packed one per lane
   always_comb begin
      for (int d = 0; d < DIMS; d++) begin
         row_data[d*COORD_BITS +: COORD_BITS] = req_tdata[SLOT_W + d*COORD_BITS +: COORD_BITS];
      end
   end

   // --------------------------------------------------------------------
   // configuration registers
   // --------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_comb begin
      num_clusters_in = num_clusters_ff;
      active_dims_in  = active_dims_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_CLUSTERS: num_clusters_in = csr_wdata[NUMC_W-1:0];
            CSR_ACTIVE_DIMS:  active_dims_in  = csr_wdata[DIMS_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------------------
   // sequencer: next state
   // --------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (cls_acc) state_in = ST_SCAN;
         ST_SCAN:   if (k_ff == nc_last_ff) state_in = ST_WAIT;
         ST_WAIT:   if (p3_vld_ff && p3_last_ff) state_in = ST_CNT_RD;
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         ST_IDLE:   req_tready = 1'b1;
         ST_SCAN:   issue      = 1'b1;
         ST_CNT_WR: finish     = out_free;
         default: ;
      endcase
   end

   // --------------------------------------------------------------------
   // point capture and effective counts
   // --------------------------------------------------------------------
   always_comb begin
      nd_eff = active_dims_ff;
      if (active_dims_ff == '0) begin
         nd_eff = DIMS_W'(1);
      end else if (32'(active_dims_ff) > 32'(DIMS)) begin
         nd_eff = DIMS_W'(DIMS);
      end
   end

   always_comb begin
      point_in   = point_ff;
      last_in    = last_ff;
      lane_en_in = lane_en_ff;
      nc_last_in = nc_last_ff;
      if (cls_acc) begin
         point_in = row_data;
         last_in  = req_tlast;
         for (int d = 0; d < DIMS; d++) begin
            lane_en_in[d] = (32'(d) < 32'(nd_eff));
         end
         if (num_clusters_ff == '0) begin
            nc_last_in = '0;
         end else if (32'(num_clusters_ff) > 32'(MAX_CLUSTERS)) begin
            nc_last_in = IDXW'(MAX_CLUSTERS - 1);
         end else begin
            nc_last_in = IDXW'(32'(num_clusters_ff) - 32'd1);
         end
      end
   end

   // centroid walk counter
   always_comb begin
      k_in = k_ff;
      if (cls_acc) begin
         k_in = '0;
      end else if (issue) begin
         k_in = k_ff + IDXW'(1);
      end
   end

   // --------------------------------------------------------------------
   // centroid RAM
   // --------------------------------------------------------------------
   nca_ram #(
      .WIDTH (ROWW),
      .DEPTH (MAX_CLUSTERS)
   ) u_cen_ram (
      .clock   (clock),
      .wr_en   (load_acc && slot_ok),
      .wr_addr (slot_idx),
      .wr_data (row_data),
      .rd_addr (k_ff),
      .rd_data (cen_rd)
   );

   // --------------------------------------------------------------------
   // distance unit: lane differences, then lane sum, then compare
   // --------------------------------------------------------------------
   assign p1_vld_in = issue;
   assign p2_vld_in = p1_vld_ff;
   assign p3_vld_in = p2_vld_ff;

   always_comb begin
      logic signed [COORD_BITS:0] a, b, diff;
      for (int d = 0; d < DIMS; d++) begin
         a    = {point_ff[d*COORD_BITS + COORD_BITS-1], point_ff[d*COORD_BITS +: COORD_BITS]};
         b    = {cen_rd[d*COORD_BITS + COORD_BITS-1], cen_rd[d*COORD_BITS +: COORD_BITS]};
         diff = a - b;
         if (!lane_en_ff[d]) begin
            abs_in[d] = '0;
         end else if (diff[COORD_BITS]) begin
            abs_in[d] = COORD_BITS'(-diff);
         end else begin
            abs_in[d] = diff[COORD_BITS-1:0];
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < DIMS; d++) begin
         sum_in = sum_in + {{(DISTW-COORD_BITS){1'b0}}, abs_ff[d]};
      end
   end

   // running minimum, lowest index kept on ties
   always_comb begin
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      if (p3_vld_ff && ((p3_idx_ff == '0) || (sum_ff < best_dist_ff))) begin
         best_dist_in = sum_ff;
         best_idx_in  = p3_idx_ff;
      end
   end

   // --------------------------------------------------------------------
   // member counts: RAM plus a valid bit per cluster
   // --------------------------------------------------------------------
   nca_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (MAX_CLUSTERS)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (best_idx_ff),
      .wr_data (cnt_new),
      .rd_addr (best_idx_ff),
      .rd_data (cnt_rd)
   );

   assign cnt_cur = cnt_vld_ff[best_idx_ff] ? cnt_rd : '0;
   assign cnt_new = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + COUNT_W'(1);

   always_comb begin
      cnt_vld_in = cnt_vld_ff;
      if (load_acc && slot_ok) begin
         cnt_vld_in[slot_idx] = 1'b0;
      end
      if (finish) begin
         cnt_vld_in[best_idx_ff] = 1'b1;
      end
   end

   // --------------------------------------------------------------------
   // output register
   // --------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign idx_wide  = {{CIDX_W{1'b0}}, best_idx_ff};
   assign dist_wide = {{DIST_OUT_W{1'b0}}, best_dist_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, out_cnt_ff, out_dist_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

   // --------------------------------------------------------------------
   // registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_clusters_ff <= NUM_CLUSTERS_RST;
         active_dims_ff  <= ACTIVE_DIMS_RST;
         p1_vld_ff       <= 1'b0;
         p2_vld_ff       <= 1'b0;
         p3_vld_ff       <= 1'b0;
         cnt_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         num_clusters_ff <= num_clusters_in;
         active_dims_ff  <= active_dims_in;
         p1_vld_ff       <= p1_vld_in;
         p2_vld_ff       <= p2_vld_in;
         p3_vld_ff       <= p3_vld_in;
         cnt_vld_ff      <= cnt_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      point_ff     <= point_in;
      last_ff      <= last_in;
      lane_en_ff   <= lane_en_in;
      nc_last_ff   <= nc_last_in;
      k_ff         <= k_in;
      p1_idx_ff    <= k_ff;
      p1_last_ff   <= (k_ff == nc_last_ff);
      p2_idx_ff    <= p1_idx_ff;
      p2_last_ff   <= p1_last_ff;
      abs_ff       <= abs_in;
      p3_idx_ff    <= p2_idx_ff;
      p3_last_ff   <= p2_last_ff;
      sum_ff       <= sum_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      if (finish) begin
         out_idx_ff  <= idx_wide[CIDX_W-1:0];
         out_dist_ff <= dist_wide[DIST_OUT_W-1:0];
         out_cnt_ff  <= cnt_new;
         out_last_ff <= last_ff;
      end
   end

   // --------------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------------
   // distance pipeline only runs during a scan
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      p3_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_WAIT))
      else $error("distance pipeline active outside a scan");

   // count read is always followed by the count update state
   a_cnt_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CNT_RD) |=> (state_ff == ST_CNT_WR))
      else $error("count read not followed by update");

   // chosen cluster lies within the searched range
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      finish |-> (best_idx_ff <= nc_last_ff))
      else $error("chosen cluster beyond searched range");

   // a freshly issued response always reports a non-zero member count
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_tvalid && out_cnt_ff != '0))
      else $error("response with zero member count");

   // no request taken while a classify is in flight
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff || p2_vld_ff || p3_vld_ff) |-> !req_tready)
      else $error("request accepted during a scan");

endmodule
`default_nettype wire
